/* src/tbpg_pkg.sv */
// Shared types and constants of the text/bitmap pixel generator.
// Used by every module of the block; depends on nothing.
package tbpg_pkg;

	// Request operation codes.
	localparam logic [2:0] OP_WR_SCREEN  = 3'd0;
	localparam logic [2:0] OP_WR_FONT    = 3'd1;
	localparam logic [2:0] OP_WR_PALETTE = 3'd2;
	localparam logic [2:0] OP_SET_CURSOR = 3'd3;
	localparam logic [2:0] OP_RENDER     = 3'd4;

	// Configuration register indexes.
	localparam logic REG_DISPLAY_MODE = 1'b0;
	localparam logic REG_COLOR_PAIR   = 1'b1;

	localparam int COLOR_PAIR_RESET = 15;
	localparam int FONT_ADDR_W      = 11;
	localparam int PALETTE_DEPTH    = 48;
	localparam int PALETTE_ENTRIES  = 16;
	localparam int RESULT_LATENCY   = 5;

	// Decoded kind of a request; at most one bit is set, none for an empty stage.
	typedef struct packed {
		logic wr_screen;
		logic wr_font;
		logic wr_palette;
		logic set_cursor;
		logic render;
	} kind_t;

	// Everything one request carries down the pipeline.
	typedef struct packed {
		kind_t       kind;
		logic [14:0] address;
		logic [7:0]  data;
		logic [14:0] scr_addr;
		logic        bmp_low;
		logic        bitmap;
		logic        in_grid;
		logic [5:0]  col;
		logic [4:0]  row;
		logic [2:0]  glyph_x;
		logic [2:0]  glyph_y;
		logic [7:0]  cur_row;
		logic [5:0]  cur_col;
		logic        cur_on;
	} stage_t;

endpackage

/* src/tbpg_front.sv */
// Stage 1 of the pixel generator: request decode and screen address calculation.
// Depends on tbpg_pkg.
module tbpg_front
	import tbpg_pkg::*;
#(
	parameter int TEXT_COLUMNS  = 40,
	parameter int TEXT_ROWS     = 25,
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        display_mode,
	input  logic [2:0]  operation,
	input  logic [14:0] address,
	input  logic [7:0]  data,
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  cursor_row,
	input  logic [5:0]  cursor_col,
	input  logic        cursor_on,
	output stage_t      item_s1
);

	stage_t      item_d;
	logic [5:0]  col;
	logic [4:0]  row;
	logic [12:0] cell_sum;
	logic [17:0] pix_num;
	logic        on_screen;

	assign col = pixel_x[8:3];
	assign row = pixel_y[7:3];

	// Text cell number and linear bitmap pixel number.
	assign cell_sum = 13'(row) * 13'(TEXT_COLUMNS) + 13'(col);
	assign pix_num  = 18'(pixel_y) * 18'(SCREEN_WIDTH) + 18'(pixel_x);

	assign on_screen = (int'(pixel_x) < SCREEN_WIDTH) && (int'(pixel_y) < SCREEN_HEIGHT);

	always_comb begin
		item_d                 = '0;
		item_d.kind.wr_screen  = accept && (operation == OP_WR_SCREEN);
		item_d.kind.wr_font    = accept && (operation == OP_WR_FONT)
			&& (int'(address) < (1 << FONT_ADDR_W));
		item_d.kind.wr_palette = accept && (operation == OP_WR_PALETTE)
			&& (int'(address) < PALETTE_DEPTH);
		item_d.kind.set_cursor = accept && (operation == OP_SET_CURSOR);
		item_d.kind.render     = accept && (operation == OP_RENDER) && on_screen;
		item_d.address         = address;
		item_d.data            = data;
		item_d.bitmap          = display_mode;
		item_d.scr_addr        = display_mode ? pix_num[15:1] : 15'(cell_sum);
		item_d.bmp_low         = pix_num[0];
		item_d.in_grid         = (int'(col) < TEXT_COLUMNS) && (int'(row) < TEXT_ROWS);
		item_d.col             = col;
		item_d.row             = row;
		item_d.glyph_x         = pixel_x[2:0];
		item_d.glyph_y         = pixel_y[2:0];
		item_d.cur_row         = cursor_row;
		item_d.cur_col         = cursor_col;
		item_d.cur_on          = cursor_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1 <= item_d;
		end
	end

endmodule

/* src/tbpg_glyph.sv */
// Stages 2 and 3: screen and font memories, their clearing sweep after reset.
// Depends on tbpg_pkg.
module tbpg_glyph
	import tbpg_pkg::*;
#(
	parameter int GLYPH_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_t     item_s1,
	output logic       clearing,
	output stage_t     item_s3,
	output logic [7:0] screen_byte_s3,
	output logic [7:0] glyph_row_s3
);

	logic [7:0]  screen_mem [32768];
	logic [7:0]  font_mem [1 << FONT_ADDR_W];
	logic [7:0]  glyph_mod [256];
	logic [14:0] clear_cnt_q;
	logic        clearing_q;
	stage_t      item_s2;
	logic [7:0]  screen_byte_s2;
	logic        scr_we;
	logic [14:0] scr_wa;
	logic [7:0]  scr_wd;
	logic        font_we;
	logic [FONT_ADDR_W-1:0] font_wa;
	logic [FONT_ADDR_W-1:0] font_ra;
	logic [7:0]  font_wd;

	// Character codes wrap at the glyph count.
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign glyph_mod[g] = 8'(g % GLYPH_COUNT);
	end

	// One entry of each store is zeroed per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clear_cnt_q <= '0;
		end else if (clearing_q) begin
			clear_cnt_q <= clear_cnt_q + 15'd1;
			if (&clear_cnt_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clearing = clearing_q;

	assign scr_we = clearing_q || item_s1.kind.wr_screen;
	assign scr_wa = clearing_q ? clear_cnt_q : item_s1.address;
	assign scr_wd = clearing_q ? 8'd0 : item_s1.data;

	always_ff @(posedge clk) begin
		if (scr_we) begin
			screen_mem[scr_wa] <= scr_wd;
		end
		screen_byte_s2 <= screen_mem[item_s1.scr_addr];
	end

	assign font_we = clearing_q || item_s2.kind.wr_font;
	assign font_wa = clearing_q ? clear_cnt_q[FONT_ADDR_W-1:0]
		: item_s2.address[FONT_ADDR_W-1:0];
	assign font_wd = clearing_q ? 8'd0 : item_s2.data;
	assign font_ra = {glyph_mod[screen_byte_s2], item_s2.glyph_y};

	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[font_wa] <= font_wd;
		end
		glyph_row_s3   <= font_mem[font_ra];
		screen_byte_s3 <= screen_byte_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
			item_s3 <= '0;
		end else begin
			item_s2 <= item_s1;
			item_s3 <= item_s2;
		end
	end

endmodule

/* src/tbpg_color.sv */
// Stages 4 and 5: cursor registers, palette index selection and palette lookup.
// Depends on tbpg_pkg.
module tbpg_color
	import tbpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] color_pair,
	input  stage_t     item_s3,
	input  logic [7:0] screen_byte_s3,
	input  logic [7:0] glyph_row_s3,
	output logic       strobe_s5,
	output logic [7:0] red_s5,
	output logic [7:0] green_s5,
	output logic [7:0] blue_s5,
	output logic [3:0] index_s5
);

	logic [7:0]  cur_row_q;
	logic [5:0]  cur_col_q;
	logic        cur_on_q;
	logic [3:0]  fg;
	logic [3:0]  bg;
	logic        cursor_hit;
	logic        pix_bit;
	logic [3:0]  idx_d;
	stage_t      item_s4;
	logic [3:0]  idx_s4;
	logic [7:0]  pal_r_q [PALETTE_ENTRIES];
	logic [7:0]  pal_g_q [PALETTE_ENTRIES];
	logic [7:0]  pal_b_q [PALETTE_ENTRIES];
	logic [5:0]  pal_addr;
	logic [12:0] pal_prod;
	logic [3:0]  pal_entry;
	logic [5:0]  pal_base;
	logic [1:0]  pal_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			cur_on_q  <= 1'b0;
		end else if (item_s3.kind.set_cursor) begin
			cur_row_q <= item_s3.cur_row;
			cur_col_q <= item_s3.cur_col;
			cur_on_q  <= item_s3.cur_on;
		end
	end

	assign fg = color_pair[3:0];
	assign bg = color_pair[7:4];
	assign cursor_hit = cur_on_q && ({3'b000, item_s3.row} == cur_row_q)
		&& (item_s3.col == cur_col_q);
	assign pix_bit = glyph_row_s3[3'd7 - item_s3.glyph_x] ^ cursor_hit;

	always_comb begin
		if (item_s3.bitmap) begin
			idx_d = item_s3.bmp_low ? screen_byte_s3[3:0] : screen_byte_s3[7:4];
		end else if (!item_s3.in_grid) begin
			idx_d = bg;
		end else begin
			idx_d = pix_bit ? fg : bg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s4 <= '0;
			idx_s4  <= '0;
		end else begin
			item_s4 <= item_s3;
			idx_s4  <= idx_d;
		end
	end

	// Byte address to entry and component: entry = address / 3 via 43/128.
	assign pal_addr  = item_s4.address[5:0];
	assign pal_prod  = 13'(pal_addr) * 13'd43;
	assign pal_entry = pal_prod[10:7];
	assign pal_base  = {1'b0, pal_entry, 1'b0} + {2'b00, pal_entry};
	assign pal_lane  = 2'(pal_addr - pal_base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				pal_r_q[i] <= '0;
				pal_g_q[i] <= '0;
				pal_b_q[i] <= '0;
			end
		end else if (item_s4.kind.wr_palette) begin
			unique case (pal_lane)
				2'd0: pal_r_q[pal_entry] <= item_s4.data;
				2'd1: pal_g_q[pal_entry] <= item_s4.data;
				default: pal_b_q[pal_entry] <= item_s4.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s5 <= 1'b0;
		end else begin
			strobe_s5 <= item_s4.kind.render;
		end
	end

	always_ff @(posedge clk) begin
		red_s5   <= pal_r_q[idx_s4];
		green_s5 <= pal_g_q[idx_s4];
		blue_s5  <= pal_b_q[idx_s4];
		index_s5 <= idx_s4;
	end

endmodule

/* src/text_bitmap_pixel_generator_top.sv */
// Top level of the text/bitmap pixel generator.
// Depends on tbpg_pkg, tbpg_front, tbpg_glyph and tbpg_color.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low. The operation port selects a screen, font or palette byte write, a
// cursor update, or a pixel render. Writes and cursor updates give no result.
// A render of a pixel on the screen gives one result: the palette index and
// its red, green and blue bytes, shown for one cycle with strobe high. A
// render outside the screen gives nothing. Results cannot be held off.
// Latency: a request taken at the end of cycle n gives its result in cycle
// n+5. One request is taken every cycle; the five register stages are
// request decode and address math, screen memory read, font memory read,
// palette index selection, and palette lookup. Each store is updated in the
// stage where it is read, so every render sees exactly the writes before it.
// Configuration (display_mode, color_pair) is written through write_enable,
// write_index and write_data, and is meant to change only while no render
// is in flight.
// Reset: busy stays high for 32768 cycles after reset while the screen and
// font memories are swept to zero, one address per cycle; configuration
// writes are taken during that time. Palette and cursor clear at once.
module text_bitmap_pixel_generator_top
	import tbpg_pkg::*;
#(
	parameter int TEXT_COLUMNS  = 40,
	parameter int TEXT_ROWS     = 25,
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200,
	parameter int GLYPH_COUNT   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [14:0] address,
	input  logic [7:0]  data,
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  cursor_row,
	input  logic [5:0]  cursor_col,
	input  logic        cursor_on,
	input  logic        write_enable,
	input  logic        write_index,
	input  logic [7:0]  write_data,
	output logic        strobe,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [3:0]  color_index
);

	logic       display_mode_q;
	logic [7:0] color_pair_q;
	logic       accept;
	logic       clearing;
	stage_t     item_s1;
	stage_t     item_s3;
	logic [7:0] screen_byte_s3;
	logic [7:0] glyph_row_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_mode_q <= 1'b0;
			color_pair_q   <= 8'(COLOR_PAIR_RESET);
		end else if (write_enable) begin
			unique case (write_index)
				REG_DISPLAY_MODE: display_mode_q <= write_data[0];
				REG_COLOR_PAIR:   color_pair_q   <= write_data;
				default:          display_mode_q <= display_mode_q;
			endcase
		end
	end

	// Requests are held off only by the clearing sweep.
	assign busy   = clearing;
	assign accept = start && !clearing;

	tbpg_front #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS),
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.display_mode(display_mode_q),
		.operation   (operation),
		.address     (address),
		.data        (data),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.cursor_on   (cursor_on),
		.item_s1     (item_s1)
	);

	tbpg_glyph #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_glyph (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.clearing      (clearing),
		.item_s3       (item_s3),
		.screen_byte_s3(screen_byte_s3),
		.glyph_row_s3  (glyph_row_s3)
	);

	tbpg_color u_color (
		.clk           (clk),
		.arst_n        (arst_n),
		.color_pair    (color_pair_q),
		.item_s3       (item_s3),
		.screen_byte_s3(screen_byte_s3),
		.glyph_row_s3  (glyph_row_s3),
		.strobe_s5     (strobe),
		.red_s5        (red),
		.green_s5      (green),
		.blue_s5       (blue),
		.index_s5      (color_index)
	);

endmodule

/* src/tbpg_checker.sv */
// Port-level checks of the pixel generator's request and result timing.
// Depends on tbpg_pkg; bound to text_bitmap_pixel_generator_top below.
module tbpg_checker
	import tbpg_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] operation,
	input logic [8:0] pixel_x,
	input logic [7:0] pixel_y,
	input logic       strobe
);

	logic taken;
	logic render_on_screen;

	assign taken = start && !busy;
	assign render_on_screen = taken && (operation == OP_RENDER)
		&& (int'(pixel_x) < SCREEN_WIDTH) && (int'(pixel_y) < SCREEN_HEIGHT);

	// No result can appear while the stores are still being cleared.
	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !strobe)
		else $error("result strobe while busy");

	// Every on-screen render gives a result.
	a_render_result: assert property (@(posedge clk) disable iff (!arst_n)
		render_on_screen |-> ##RESULT_LATENCY strobe)
		else $error("on-screen render gave no result");

	// Anything but a render gives no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && (operation != OP_RENDER)) |-> ##RESULT_LATENCY !strobe)
		else $error("non-render request gave a result");

	// A result always traces back to an on-screen render.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(render_on_screen, RESULT_LATENCY))
		else $error("result without a matching render");

endmodule

bind text_bitmap_pixel_generator_top tbpg_checker #(
	.SCREEN_WIDTH (SCREEN_WIDTH),
	.SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.pixel_x  (pixel_x),
	.pixel_y  (pixel_y),
	.strobe   (strobe)
);

/* test/text_bitmap_pixel_generator_checker.sv */
// Scoreboard for the text/bitmap pixel generator: keeps its own copy of the stores,
// predicts each rendered pixel and compares it with the block's result.
// Depends on tbpg_pkg for operation codes, register indexes and store sizes.
`timescale 1ns / 1ps

module text_bitmap_pixel_generator_checker
	import tbpg_pkg::*;
#(
	parameter int TEXT_COLUMNS  = 40,
	parameter int TEXT_ROWS     = 25,
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200,
	parameter int GLYPH_COUNT   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [14:0] address,
	input  logic [7:0]  data,
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  cursor_row,
	input  logic [5:0]  cursor_col,
	input  logic        cursor_on,
	input  logic        write_enable,
	input  logic        write_index,
	input  logic [7:0]  write_data,
	input  logic        strobe,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [3:0]  color_index,
	output int          mismatch_count,
	output int          pixels_due,
	output int          requests_taken,
	output int          renders_taken,
	output int          pixels_checked
);

	localparam int SCREEN_DEPTH = 32768;
	localparam int FONT_DEPTH   = 1 << FONT_ADDR_W;

	typedef enum logic {
		TEXT_MODE   = 1'b0,
		BITMAP_MODE = 1'b1
	} display_mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [3:0] index;
	} pixel_t;

	logic [7:0]    screen_mem [SCREEN_DEPTH];
	logic [7:0]    font_mem [FONT_DEPTH];
	logic [7:0]    palette_mem [PALETTE_DEPTH];
	logic [7:0]    cursor_row_q;
	logic [5:0]    cursor_col_q;
	logic          cursor_on_q;
	display_mode_t mode_q;
	logic [7:0]    pair_q;
	pixel_t        expected_pixels [$];

	// Text mode: glyph bit of the character cell, inverted in the cursor cell.
	function automatic logic [3:0] text_pixel_index(input int x, input int y);
		int   col;
		int   row;
		int   code;
		logic [7:0] glyph;
		logic lit;
		col = x / 8;
		row = y / 8;
		if (col >= TEXT_COLUMNS || row >= TEXT_ROWS)
			return pair_q[7:4];
		code = int'(screen_mem[15'((row * TEXT_COLUMNS + col) % SCREEN_DEPTH)])
			% GLYPH_COUNT;
		glyph = font_mem[FONT_ADDR_W'((code * 8 + y % 8) % FONT_DEPTH)];
		lit = glyph[3'(7 - x % 8)];
		if (cursor_on_q && row == int'(cursor_row_q) && col == int'(cursor_col_q))
			lit = !lit;
		return lit ? pair_q[3:0] : pair_q[7:4];
	endfunction

	// Bitmap mode: two pixels per byte, the even pixel in the high nibble.
	function automatic logic [3:0] bitmap_pixel_index(input int x, input int y);
		int n;
		logic [7:0] pair_byte;
		n = y * SCREEN_WIDTH + x;
		pair_byte = screen_mem[15'((n / 2) % SCREEN_DEPTH)];
		return (n % 2 != 0) ? pair_byte[3:0] : pair_byte[7:4];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		pixel_t got;
		int     x;
		int     y;
		int     idx;
		if (!arst_n) begin
			foreach (screen_mem[i])
				screen_mem[i] = '0;
			foreach (font_mem[i])
				font_mem[i] = '0;
			foreach (palette_mem[i])
				palette_mem[i] = '0;
			cursor_row_q = '0;
			cursor_col_q = '0;
			cursor_on_q = 1'b0;
			mode_q = TEXT_MODE;
			pair_q = 8'(COLOR_PAIR_RESET);
			expected_pixels.delete();
			mismatch_count <= 0;
			pixels_due <= 0;
			requests_taken <= 0;
			renders_taken <= 0;
			pixels_checked <= 0;
		end else begin
			if (write_enable) begin
				if (write_index == REG_DISPLAY_MODE)
					mode_q = display_mode_t'(write_data[0]);
				else
					pair_q = write_data;
			end

			if (strobe) begin
				got = '{red: red, green: green, blue: blue, index: color_index};
				if (expected_pixels.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: pixel result with no render pending: idx %0d rgb %h %h %h",
							$realtime, color_index, red, green, blue);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked <= pixels_checked + 1;
					if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.index !== want.index) begin
						if (mismatch_count < 10)
							$display("%0t: pixel mismatch: expected idx %0d rgb %h %h %h, got idx %0d rgb %h %h %h",
								$realtime, want.index, want.red, want.green, want.blue,
								got.index, got.red, got.green, got.blue);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end

			if (start && !busy) begin
				requests_taken <= requests_taken + 1;
				case (operation)
					OP_WR_SCREEN:
						screen_mem[address] = data;
					OP_WR_FONT:
						if (int'(address) < FONT_DEPTH)
							font_mem[address[FONT_ADDR_W-1:0]] = data;
					OP_WR_PALETTE:
						if (int'(address) < PALETTE_DEPTH)
							palette_mem[address[5:0]] = data;
					OP_SET_CURSOR: begin
						cursor_row_q = cursor_row;
						cursor_col_q = cursor_col;
						cursor_on_q = cursor_on;
					end
					OP_RENDER: begin
						renders_taken <= renders_taken + 1;
						x = int'(pixel_x);
						y = int'(pixel_y);
						if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
							if (mode_q == BITMAP_MODE)
								idx = int'(bitmap_pixel_index(x, y));
							else
								idx = int'(text_pixel_index(x, y));
							want.red = palette_mem[6'(idx * 3)];
							want.green = palette_mem[6'(idx * 3 + 1)];
							want.blue = palette_mem[6'(idx * 3 + 2)];
							want.index = 4'(idx);
							expected_pixels.push_back(want);
						end
					end
					default: ;
				endcase
			end
			pixels_due <= expected_pixels.size();
		end
	end

endmodule

/* test/testbench.sv */
// Top of the pixel generator testbench: clock, reset, request and register stimulus.
// Depends on tbpg_pkg, text_bitmap_pixel_generator_top and the checker module.
`timescale 1ns / 1ps

module testbench;
	import tbpg_pkg::*;

	localparam int TEXT_COLUMNS  = 40;
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 105;
	// The clearing sweep after reset, which keeps busy high, is by far the
	// longest stretch with no request taken; allow several times its length.
	localparam int STALL_LIMIT   = 150000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = OP_WR_SCREEN;
	logic [14:0] address = '0;
	logic [7:0]  data = '0;
	logic [8:0]  pixel_x = '0;
	logic [7:0]  pixel_y = '0;
	logic [7:0]  cursor_row = '0;
	logic [5:0]  cursor_col = '0;
	logic        cursor_on = 1'b0;
	logic        write_enable = 1'b0;
	logic        write_index = REG_DISPLAY_MODE;
	logic [7:0]  write_data = '0;
	logic        strobe;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [3:0]  color_index;

	int mismatch_count;
	int pixels_due;
	int requests_taken;
	int renders_taken;
	int pixels_checked;
	int idle_pct = 0;
	int stall_cycles = 0;

	// Each phase sets a display mode, a color pair and how often the sender idles.
	// Phase 0 runs with no gaps at all; the pairs include both extremes, where the
	// foreground equals the background.
	logic       phase_mode [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	logic [7:0] phase_pair [PHASES] = '{8'h1E, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h0F};
	int         phase_idle [PHASES] = '{0, 52, 0, 15, 52, 15, 15, 52};

	always #4ns clk = ~clk;

	text_bitmap_pixel_generator_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.address     (address),
		.data        (data),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.cursor_on   (cursor_on),
		.write_enable(write_enable),
		.write_index (write_index),
		.write_data  (write_data),
		.strobe      (strobe),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.color_index (color_index)
	);

	text_bitmap_pixel_generator_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.address       (address),
		.data          (data),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.cursor_row    (cursor_row),
		.cursor_col    (cursor_col),
		.cursor_on     (cursor_on),
		.write_enable  (write_enable),
		.write_index   (write_index),
		.write_data    (write_data),
		.strobe        (strobe),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.color_index   (color_index),
		.mismatch_count(mismatch_count),
		.pixels_due    (pixels_due),
		.requests_taken(requests_taken),
		.renders_taken (renders_taken),
		.pixels_checked(pixels_checked)
	);

	// Watchdog: any cycle where neither a request nor a result is taken counts
	// toward the limit; a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired: no request or result for %0d cycles.", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one request and returns at the edge where it is taken. Start is
	// left high, so the caller must either present the next request or drop
	// start within the same time step, or the request would be taken twice.
	task automatic send_request(input logic [2:0] op, input logic [14:0] addr,
		input logic [7:0] dat, input logic [8:0] px, input logic [7:0] py,
		input logic [7:0] crow, input logic [5:0] ccol, input logic con);
		int gap;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		address <= addr;
		data <= dat;
		pixel_x <= px;
		pixel_y <= py;
		cursor_row <= crow;
		cursor_col <= ccol;
		cursor_on <= con;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Renders a pixel with every other field random.
	task automatic send_render(input int px, input int py);
		send_request(OP_RENDER, 15'($urandom_range(32767)), 8'($urandom_range(255)),
			9'(px), 8'(py), 8'($urandom_range(255)), 6'($urandom_range(63)),
			1'($urandom_range(1)));
	endtask

	// A store write with the pixel and cursor fields random.
	task automatic send_write(input logic [2:0] op, input int addr, input int dat);
		send_request(op, 15'(addr), 8'(dat), 9'($urandom_range(511)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 6'($urandom_range(63)),
			1'($urandom_range(1)));
	endtask

	task automatic send_cursor(input int crow, input int ccol, input logic con);
		send_request(OP_SET_CURSOR, 15'($urandom_range(32767)), 8'($urandom_range(255)),
			9'($urandom_range(511)), 8'($urandom_range(255)), 8'(crow), 6'(ccol), con);
	endtask

	// Mostly requests aimed at a small corner of the screen (8x2 text cells) so
	// that screen, font and palette writes actually land where renders read,
	// plus full-range writes, off-screen renders and unused operation codes.
	// Ignored requests are reported back so they do not count toward the total.
	task automatic send_random_request(input logic bitmap, output bit useful);
		int pick;
		int hx;
		int hy;
		int addr;
		int dat;
		hx = $urandom_range(63);
		hy = $urandom_range(15);
		addr = $urandom_range(32767);
		dat = $urandom_range(255);
		pick = $urandom_range(99);
		useful = 1'b1;
		if (pick < 40) begin
			send_render(hx, hy);
		end else if (pick < 52) begin
			send_render($urandom_range(SCREEN_WIDTH - 1), $urandom_range(SCREEN_HEIGHT - 1));
		end else if (pick < 55) begin
			useful = 1'b0;
			if ($urandom_range(1) != 0)
				send_render($urandom_range(511, SCREEN_WIDTH), $urandom_range(255));
			else
				send_render($urandom_range(SCREEN_WIDTH - 1),
					$urandom_range(255, SCREEN_HEIGHT));
		end else if (pick < 70) begin
			if ($urandom_range(3) != 0) begin
				if (bitmap) begin
					addr = (hy * SCREEN_WIDTH + hx) / 2;
				end else begin
					addr = (hy / 8) * TEXT_COLUMNS + hx / 8;
					// Small character codes hit the glyphs that font writes target.
					if ($urandom_range(1) != 0)
						dat = $urandom_range(7);
				end
			end
			send_write(OP_WR_SCREEN, addr, dat);
		end else if (pick < 80) begin
			if ($urandom_range(4) != 0)
				addr = $urandom_range(63);
			useful = addr < (1 << FONT_ADDR_W);
			send_write(OP_WR_FONT, addr, dat);
		end else if (pick < 90) begin
			if ($urandom_range(6) != 0)
				addr = $urandom_range(PALETTE_DEPTH - 1);
			useful = addr < PALETTE_DEPTH;
			send_write(OP_WR_PALETTE, addr, dat);
		end else if (pick < 96) begin
			if ($urandom_range(9) < 7)
				send_cursor($urandom_range(1), $urandom_range(7), 1'($urandom_range(1)));
			else
				send_cursor($urandom_range(255), $urandom_range(63), 1'($urandom_range(1)));
		end else begin
			useful = 1'b0;
			send_request(OP_RENDER + 3'($urandom_range(3, 1)), 15'(addr), 8'(dat),
				9'($urandom_range(511)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 6'($urandom_range(63)), 1'($urandom_range(1)));
		end
	endtask

	// Writes both registers on consecutive edges; only called with the block idle.
	// The spare bits of the mode write are random, since only bit 0 counts.
	task automatic write_display_config(input logic mode, input logic [7:0] pair);
		write_enable <= 1'b1;
		write_index <= REG_DISPLAY_MODE;
		write_data <= {7'($urandom_range(127)), mode};
		@(posedge clk);
		write_index <= REG_COLOR_PAIR;
		write_data <= pair;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	// Drops start and waits until every predicted pixel has come back.
	task automatic wait_pixels_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pixels_due != 0);
	endtask

	initial begin : stimulus
		int  n;
		bit  useful;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			// Between phases the pipeline is flushed first; renders off the
			// screen leave no result behind, so the full latency is waited out
			// before the registers change.
			if (p != 0) begin
				wait_pixels_drained();
				repeat (RESULT_LATENCY + 2) @(posedge clk);
			end
			write_display_config(phase_mode[p], phase_pair[p]);
			idle_pct = phase_idle[p];

			if (p == 0) begin
				// Directed opening, in text mode with foreground 14 on background 1.
				// The first request waits out the clearing sweep after reset.
				send_write(OP_WR_PALETTE, 0, 8'hFF);
				send_write(OP_WR_PALETTE, PALETTE_DEPTH - 1, 8'hA5);
				send_write(OP_WR_PALETTE, 3, 8'h12);
				send_write(OP_WR_PALETTE, 42, 8'h34);
				send_write(OP_WR_PALETTE, 43, 8'h56);
				// Palette and font writes past the end of their stores are ignored.
				send_write(OP_WR_PALETTE, PALETTE_DEPTH, 8'h77);
				send_write(OP_WR_PALETTE, 32767, 8'h11);
				send_write(OP_WR_FONT, 0, 8'h81);
				send_write(OP_WR_FONT, (1 << FONT_ADDR_W) - 1, 8'hFF);
				send_write(OP_WR_FONT, 1 << FONT_ADDR_W, 8'h00);
				// Top screen address, outside the text grid, and the last cell of
				// the first row holding the last glyph.
				send_write(OP_WR_SCREEN, 32767, 8'hFF);
				send_write(OP_WR_SCREEN, TEXT_COLUMNS - 1, 8'hFF);
				send_render(0, 0);
				send_render(1, 0);
				send_render(SCREEN_WIDTH - 1, 7);
				send_render(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
				// Renders just off the screen and at the field maxima give nothing.
				send_render(SCREEN_WIDTH, 0);
				send_render(0, SCREEN_HEIGHT);
				send_render(511, 255);
				for (int k = 1; k <= 3; k++)
					send_request(OP_RENDER + 3'(k), 15'($urandom_range(32767)),
						8'($urandom_range(255)), 9'($urandom_range(511)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						6'($urandom_range(63)), 1'($urandom_range(1)));
				// Cursor on the first cell swaps its colors; a cursor outside the
				// grid matches no cell.
				send_cursor(0, 0, 1'b1);
				send_render(0, 0);
				send_render(7, 0);
				send_cursor(255, 63, 1'b1);
				send_render(0, 0);
			end

			n = 0;
			while (n < PHASE_ITEMS) begin
				send_random_request(phase_mode[p], useful);
				if (useful) begin
					n++;
					// Halfway through each phase the sender holds off until every
					// outstanding pixel has arrived, then resumes.
					if (n == PHASE_ITEMS / 2)
						wait_pixels_drained();
				end
			end
		end

		wait_pixels_drained();
		repeat (RESULT_LATENCY + 2) @(posedge clk);

		$display("Run covered %0d requests with %0d renders and %0d pixels compared,",
			requests_taken, renders_taken, pixels_checked);
		$display("over %0d register settings in text and bitmap mode with varied sender gaps.",
			PHASES);
		if (mismatch_count == 0 && pixels_due == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
